// ----- hw/rtl/mipc_pkg.sv -----
// Shared types and constants for the multi-image pixel combiner.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package mipc_pkg;

    localparam int SAMPLE_W       = 8;
    localparam int WEIGHT_W       = 16;
    localparam int Q_FRAC         = 15;
    localparam int TERM_W         = SAMPLE_W + WEIGHT_W - Q_FRAC;
    localparam int QUO_W          = SAMPLE_W;
    localparam int CNT_W          = 3;
    localparam int MODE_W         = 2;
    localparam int CFG_LANES      = 4;
    localparam int MAX_INPUTS_DEF = 4;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(32768);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_AVG  = 2'd0,
        MODE_MAX  = 2'd1,
        MODE_MIN  = 2'd2,
        MODE_RSVD = 2'd3
    } mode_t;

    typedef enum logic [ADDR_W-3:0] {
        REG_MODE         = 3'd0,
        REG_INPUT_COUNT  = 3'd1,
        REG_USE_WEIGHTS  = 3'd2,
        REG_WEIGHT_ZERO  = 3'd3,
        REG_WEIGHT_ONE   = 3'd4,
        REG_WEIGHT_TWO   = 3'd5,
        REG_WEIGHT_THREE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_zero;
        logic [SAMPLE_W-1:0] sample_one;
        logic [SAMPLE_W-1:0] sample_two;
        logic [SAMPLE_W-1:0] sample_three;
    } pix_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] combined;
        logic                zero_weight_fault;
    } res_t;

    typedef struct packed {
        mode_t            mode;
        logic             use_weights;
        logic [CNT_W-1:0] lanes;
    } cfg_t;

    typedef struct packed {
        logic                active;
        logic [SAMPLE_W-1:0] sample;
        logic [TERM_W-1:0]   wterm;
        logic [WEIGHT_W-1:0] weight;
    } lane_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mipc_lane.sv -----
// One lane: weights its sample and registers the masked lane terms.
// Depends on mipc_pkg.
`default_nettype none

module mipc_lane
    import mipc_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic                active,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [WEIGHT_W-1:0] weight,
    output lane_t               lane
);

    logic [SAMPLE_W+WEIGHT_W-1:0] prod;
    lane_t                        lane_next;
    lane_t                        lane_reg;

    assign prod = sample * weight;

    always_comb
    begin
        lane_next.active = active;
        lane_next.sample = sample;
        // floor(sample * weight / 2^15); drop the lane's terms when unused
        lane_next.wterm  = active ? prod[SAMPLE_W+WEIGHT_W-1:Q_FRAC] : '0;
        lane_next.weight = active ? weight : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mipc_merge.sv -----
// Merge stage: reduces the lane terms and picks the divide operands or a direct result.
// Depends on mipc_pkg.
`default_nettype none

module mipc_merge
    import mipc_pkg::*;
#(
    parameter int NL = MAX_INPUTS_DEF,
    parameter int NW = TERM_W + 2 + Q_FRAC,
    parameter int DW = WEIGHT_W + 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  cfg_t          cfg,
    input  lane_t         lanes [NL],
    output logic          v,
    output logic [NW-1:0] dividend,
    output logic [DW-1:0] divisor,
    output logic          use_div,
    output res_t          side
);

    localparam int ACC_W = NW - Q_FRAC;
    localparam int SUM_W = SAMPLE_W + $clog2(NL);

    logic [ACC_W-1:0]    acc;
    logic [DW-1:0]       wsum;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] mx;
    logic [SAMPLE_W-1:0] mn;

    logic                v_reg;
    logic [NW-1:0]       dvd_next, dvd_reg;
    logic [DW-1:0]       dvs_next, dvs_reg;
    logic                use_next, use_reg;
    res_t                side_next, side_reg;

    always_comb
    begin
        acc  = '0;
        wsum = '0;
        sum  = '0;
        mx   = '0;
        mn   = SAMPLE_MAX;
        for (int i = 0; i < NL; i++)
        begin
            if (lanes[i].active)
            begin
                acc  = acc + ACC_W'(lanes[i].wterm);
                wsum = wsum + DW'(lanes[i].weight);
                sum  = sum + SUM_W'(lanes[i].sample);
                if (lanes[i].sample > mx)
                begin
                    mx = lanes[i].sample;
                end
                if (lanes[i].sample < mn)
                begin
                    mn = lanes[i].sample;
                end
            end
        end
    end

    always_comb
    begin
        dvd_next  = '0;
        dvs_next  = DW'(1);
        use_next  = 1'b0;
        side_next = '0;
        unique case (cfg.mode)
            MODE_AVG:
            begin
                if (cfg.use_weights)
                begin
                    if (wsum == '0)
                    begin
                        side_next.zero_weight_fault = 1'b1;
                    end
                    else
                    begin
                        use_next = 1'b1;
                        dvd_next = NW'(acc) << Q_FRAC;
                        dvs_next = wsum;
                    end
                end
                else
                begin
                    use_next = 1'b1;
                    dvd_next = NW'(sum);
                    dvs_next = DW'(cfg.lanes);
                end
            end
            MODE_MAX:  side_next.combined = mx;
            MODE_MIN:  side_next.combined = mn;
            MODE_RSVD: side_next.combined = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvd_reg  <= dvd_next;
            dvs_reg  <= dvs_next;
            use_reg  <= use_next;
            side_reg <= side_next;
        end
    end

    assign v        = v_reg;
    assign dividend = dvd_reg;
    assign divisor  = dvs_reg;
    assign use_div  = use_reg;
    assign side     = side_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/mipc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; carries a bypass result.
// Depends on mipc_pkg.
`default_nettype none

module mipc_div
    import mipc_pkg::*;
#(
    parameter int NW = TERM_W + 2 + Q_FRAC,
    parameter int DW = WEIGHT_W + 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_v,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    input  logic          use_div,
    input  res_t          side,
    output logic          out_v,
    output res_t          result
);

    localparam int CMP_W = (NW > DW + QUO_W) ? NW : DW + QUO_W;

    logic             v_reg    [QUO_W];
    logic [CMP_W-1:0] rem_reg  [QUO_W];
    logic [DW-1:0]    dvs_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    logic             use_reg  [QUO_W];
    res_t             side_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int B = QUO_W - 1 - k;

        logic             v_prev;
        logic [CMP_W-1:0] rem_prev;
        logic [DW-1:0]    dvs_prev;
        logic [QUO_W-1:0] quo_prev;
        logic             use_prev;
        res_t             side_prev;
        logic [CMP_W-1:0] shifted;
        logic             fits;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_v;
            assign rem_prev  = CMP_W'(dividend);
            assign dvs_prev  = divisor;
            assign quo_prev  = '0;
            assign use_prev  = use_div;
            assign side_prev = side;
        end
        else
        begin : g_next
            assign v_prev    = v_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign dvs_prev  = dvs_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign use_prev  = use_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // try the divisor at this quotient bit's weight
        assign shifted = CMP_W'(dvs_prev) << B;
        assign fits    = rem_prev >= shifted;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= fits ? rem_prev - shifted : rem_prev;
                dvs_reg[k]  <= dvs_prev;
                quo_reg[k]  <= {quo_prev[QUO_W-2:0], fits};
                use_reg[k]  <= use_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_v = v_reg[QUO_W-1];

    always_comb
    begin
        if (use_reg[QUO_W-1])
        begin
            result.combined          = quo_reg[QUO_W-1];
            result.zero_weight_fault = 1'b0;
        end
        else
        begin
            result = side_reg[QUO_W-1];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/multi_image_pixel_combiner.sv -----
// Top level of the multi-image pixel combiner: registers, lanes, merge, divider, output.
// Depends on mipc_pkg, mipc_lane, mipc_merge and mipc_div.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  pix     | in        | pix_valid / pix_stall   | pix_t: four 8-bit samples
//  res     | out       | res_valid / res_stall   | res_t: combined, zero_weight_fault
//  apb     | in        | psel / penable / pready | paddr, pwdata, prdata (registers)
//
// One pixel transfer per clock while pix_stall is low; each result passes through, in order, the
// lane multiply, merge, eight divider stages (one quotient bit each), output register.
// rst_n clears all valid flags and loads the register reset values; no clearing pass.
// A stalled output fills a single skid entry; pix_stall is that entry's full flag,
// so the input stalls in the cycle after a divider result meets a stalled output.
`default_nettype none

module multi_image_pixel_combiner
    import mipc_pkg::*;
#(
    parameter int MAX_INPUTS = MAX_INPUTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  pix_t              pix,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int NL = (MAX_INPUTS < CFG_LANES) ? MAX_INPUTS : CFG_LANES;
    localparam int LG = $clog2(NL);
    localparam int NW = TERM_W + LG + Q_FRAC;
    localparam int DW = WEIGHT_W + LG;

    mode_t               mode_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                use_w_reg;
    logic [WEIGHT_W-1:0] weight_reg [CFG_LANES];
    reg_idx_t            idx;
    logic                wr;

    logic [CNT_W-1:0]    lanes_used;
    cfg_t                cfg;
    logic [SAMPLE_W-1:0] samples [CFG_LANES];
    lane_t               lanes [NL];
    logic                en;
    logic                lane_v_reg;

    logic                mg_v;
    logic [NW-1:0]       mg_dvd;
    logic [DW-1:0]       mg_dvs;
    logic                mg_use;
    res_t                mg_side;
    logic                dv_v;
    res_t                dv_res;

    logic                res_valid_reg;
    res_t                res_reg;
    logic                skid_full_reg;
    res_t                skid_reg;
    logic                take;

    // ---------------- configuration port
    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_AVG;
            count_reg <= CNT_W'(CFG_LANES);
            use_w_reg <= 1'b0;
            for (int i = 0; i < CFG_LANES; i++)
            begin
                weight_reg[i] <= WEIGHT_ONE;
            end
        end
        else if (wr)
        begin
            unique case (idx)
                REG_MODE:         mode_reg      <= mode_t'(pwdata[MODE_W-1:0]);
                REG_INPUT_COUNT:  count_reg     <= pwdata[CNT_W-1:0];
                REG_USE_WEIGHTS:  use_w_reg     <= pwdata[0];
                REG_WEIGHT_ZERO:  weight_reg[0] <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_ONE:   weight_reg[1] <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_TWO:   weight_reg[2] <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_THREE: weight_reg[3] <= pwdata[WEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODE:         prdata = DATA_W'(mode_reg);
            REG_INPUT_COUNT:  prdata = DATA_W'(count_reg);
            REG_USE_WEIGHTS:  prdata = DATA_W'(use_w_reg);
            REG_WEIGHT_ZERO:  prdata = DATA_W'(weight_reg[0]);
            REG_WEIGHT_ONE:   prdata = DATA_W'(weight_reg[1]);
            REG_WEIGHT_TWO:   prdata = DATA_W'(weight_reg[2]);
            REG_WEIGHT_THREE: prdata = DATA_W'(weight_reg[3]);
            default:          prdata = '0;
        endcase
    end

    // clamp the lane count into 1..NL
    always_comb
    begin
        priority if (count_reg == '0)
        begin
            lanes_used = CNT_W'(1);
        end
        else if (count_reg > CNT_W'(NL))
        begin
            lanes_used = CNT_W'(NL);
        end
        else
        begin
            lanes_used = count_reg;
        end
    end

    assign cfg.mode        = mode_reg;
    assign cfg.use_weights = use_w_reg;
    assign cfg.lanes       = lanes_used;

    // ---------------- datapath
    assign en        = !skid_full_reg;
    assign pix_stall = skid_full_reg;

    assign samples[0] = pix.sample_zero;
    assign samples[1] = pix.sample_one;
    assign samples[2] = pix.sample_two;
    assign samples[3] = pix.sample_three;

    for (genvar i = 0; i < NL; i++)
    begin : g_lane
        mipc_lane u_lane (
            .clk    (clk),
            .en     (en),
            .active (CNT_W'(i) < lanes_used),
            .sample (samples[i]),
            .weight (weight_reg[i]),
            .lane   (lanes[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_v_reg <= 1'b0;
        end
        else if (en)
        begin
            lane_v_reg <= pix_valid;
        end
    end

    mipc_merge #(
        .NL (NL),
        .NW (NW),
        .DW (DW)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (lane_v_reg),
        .cfg      (cfg),
        .lanes    (lanes),
        .v        (mg_v),
        .dividend (mg_dvd),
        .divisor  (mg_dvs),
        .use_div  (mg_use),
        .side     (mg_side)
    );

    mipc_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_v     (mg_v),
        .dividend (mg_dvd),
        .divisor  (mg_dvs),
        .use_div  (mg_use),
        .side     (mg_side),
        .out_v    (dv_v),
        .result   (dv_res)
    );

    // ---------------- output register and skid entry
    assign take = res_valid_reg && !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (!res_valid_reg || take)
        begin
            if (skid_full_reg)
            begin
                res_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
            else
            begin
                res_valid_reg <= dv_v;
            end
        end
        else if (dv_v && en)
        begin
            skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!res_valid_reg || take)
        begin
            res_reg <= skid_full_reg ? skid_reg : dv_res;
        end
        else if (dv_v && en)
        begin
            skid_reg <= dv_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ---------------- assertions
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> res_valid_reg)
        else $error("skid entry full while output register empty");

    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(res_valid_reg && res_stall))
        else $error("skid entry filled without a stalled output");

    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.zero_weight_fault) |-> (res_reg.combined == '0))
        else $error("zero weight fault with non-zero result");

    a_fault_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.zero_weight_fault)
            |-> (mode_reg == MODE_AVG && use_w_reg))
        else $error("zero weight fault outside weighted average");

endmodule

`default_nettype wire
